// ===== hw/rtl/msp_pkg.sv =====
// Shared types, codes and the CRC-8 helper for the serial control frame parser.
package msp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned KindW = 3;

  localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;
  localparam logic [ByteW-1:0] CH_M      = 8'h4D;
  localparam logic [ByteW-1:0] CH_X      = 8'h58;
  localparam logic [ByteW-1:0] CH_QUERY  = 8'h3F;
  localparam logic [ByteW-1:0] CH_LT     = 8'h3C;
  localparam logic [ByteW-1:0] CH_GT     = 8'h3E;

  localparam logic [ByteW-1:0] CRC_POLY = 8'hD5;
  localparam logic [ByteW-1:0] CRC_MSB  = 8'h80;

  localparam logic [KindW-1:0] KIND_V1_CMD  = 3'd0;
  localparam logic [KindW-1:0] KIND_V1_RESP = 3'd1;
  localparam logic [KindW-1:0] KIND_V1_FLAG = 3'd2;
  localparam logic [KindW-1:0] KIND_V2_CMD  = 3'd3;
  localparam logic [KindW-1:0] KIND_V2_RESP = 3'd4;

  // Header byte positions of a version 2 frame.
  localparam logic [WordW-1:0] V2_FLAGS  = 16'd0;
  localparam logic [WordW-1:0] V2_FUNC_L = 16'd1;
  localparam logic [WordW-1:0] V2_FUNC_H = 16'd2;
  localparam logic [WordW-1:0] V2_LEN_L  = 16'd3;
  localparam logic [WordW-1:0] V2_LAST   = 16'd4;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_START = 12'b0000_0000_0010,
    ST_HDR_M = 12'b0000_0000_0100,
    ST_FLAGS = 12'b0000_0000_1000,
    ST_SIZE1 = 12'b0000_0001_0000,
    ST_FUNC1 = 12'b0000_0010_0000,
    ST_PAY1  = 12'b0000_0100_0000,
    ST_CHK1  = 12'b0000_1000_0000,
    ST_HDR_X = 12'b0001_0000_0000,
    ST_HDR2  = 12'b0010_0000_0000,
    ST_PAY2  = 12'b0100_0000_0000,
    ST_CHK2  = 12'b1000_0000_0000
  } state_t;

  // One byte of CRC-8 (DVB-S2), MSB first.
  function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] acc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/msp_in_if.sv =====
// Input channel: one received serial byte per beat.
interface msp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/msp_out_if.sv =====
// Result channel: payload byte and frame status, one beat per received byte.
interface msp_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        frame_ok;
  logic        crc_fail;
  logic [2:0]  frame_kind;
  logic [15:0] function_id;
  logic [7:0]  frame_flags;
  logic [15:0] payload_len;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_index, output frame_ok, output crc_fail,
                  output frame_kind, output function_id, output frame_flags,
                  output payload_len, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input payload_index, input frame_ok, input crc_fail,
                input frame_kind, input function_id, input frame_flags,
                input payload_len, output ready);
endinterface

// ===== hw/rtl/msp_frame_parser.sv =====
// Parser for serial control frames, versions 1 and 2, one received byte per beat.
// Every received byte produces exactly one result beat in the cycle after it is taken, and a
// new byte is accepted every cycle: the frame state, checksum and header registers update
// in the accepting cycle, and the result sits in a single output register that is refilled
// in the same cycle it is drained, so throughput is one byte per clock and the only stall
// is a held output. Version 1 frames use an XOR checksum, version 2 frames a CRC-8 with
// polynomial 0xD5 computed one byte per cycle. The header fields on each result show the
// frame registers after that byte; after the checksum byte the parser returns to idle.
module msp_frame_parser (
  input  logic      clk,
  input  logic      rst_n,
  msp_in_if.sink    in_bus,
  msp_out_if.source out_bus
);
  import msp_pkg::*;

  state_t           state_r, state_nxt;
  logic [ByteW-1:0] crc_r, crc_nxt;
  logic [WordW-1:0] cnt_r, cnt_nxt;
  logic [WordW-1:0] len_r, len_nxt;
  logic [WordW-1:0] func_r, func_nxt;
  logic [ByteW-1:0] flags_r, flags_nxt;
  logic [KindW-1:0] kind_r, kind_nxt;

  logic             pv, ok, fail;
  logic [WordW-1:0] cnt_inc;
  logic [ByteW-1:0] c;
  logic             in_fire;

  logic             out_valid_r;
  logic             pv_r, ok_r, fail_r;
  logic [ByteW-1:0] pb_r;
  logic [WordW-1:0] pi_r;
  logic [KindW-1:0] kind_out_r;
  logic [WordW-1:0] func_out_r, len_out_r;
  logic [ByteW-1:0] flags_out_r;

  assign c       = in_bus.rx_byte;
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire = in_bus.valid && in_bus.ready;
  assign cnt_inc = cnt_r + 16'd1;

  always_comb begin
    state_nxt = state_r;
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    func_nxt  = func_r;
    flags_nxt = flags_r;
    kind_nxt  = kind_r;
    pv        = 1'b0;
    ok        = 1'b0;
    fail      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (c == CH_DOLLAR) state_nxt = ST_START;
      end
      ST_START: begin
        if (c == CH_X) state_nxt = ST_HDR_X;
        else if (c == CH_M) state_nxt = ST_HDR_M;
        else state_nxt = ST_IDLE;
      end
      ST_HDR_M, ST_HDR_X: begin
        // The type byte starts a fresh frame whatever it turns out to be.
        len_nxt   = '0;
        func_nxt  = '0;
        flags_nxt = '0;
        kind_nxt  = KIND_V1_CMD;
        cnt_nxt   = '0;
        crc_nxt   = '0;
        state_nxt = ST_IDLE;
        if (state_r == ST_HDR_M) begin
          if (c == CH_QUERY) begin
            kind_nxt = KIND_V1_FLAG;  state_nxt = ST_FLAGS;
          end else if (c == CH_LT) begin
            kind_nxt = KIND_V1_CMD;   state_nxt = ST_SIZE1;
          end else if (c == CH_GT) begin
            kind_nxt = KIND_V1_RESP;  state_nxt = ST_SIZE1;
          end
        end else begin
          if (c == CH_LT) begin
            kind_nxt = KIND_V2_CMD;   state_nxt = ST_HDR2;
          end else if (c == CH_GT) begin
            kind_nxt = KIND_V2_RESP;  state_nxt = ST_HDR2;
          end
        end
      end
      ST_FLAGS: begin
        flags_nxt = c;
        state_nxt = ST_SIZE1;
      end
      ST_SIZE1: begin
        len_nxt   = {8'd0, c};
        crc_nxt   = crc_r ^ c;
        state_nxt = ST_FUNC1;
      end
      ST_FUNC1: begin
        func_nxt  = {8'd0, c};
        crc_nxt   = crc_r ^ c;
        cnt_nxt   = '0;
        state_nxt = (len_r == '0) ? ST_CHK1 : ST_PAY1;
      end
      ST_PAY1, ST_PAY2: begin
        pv      = 1'b1;
        crc_nxt = (state_r == ST_PAY1) ? (crc_r ^ c) : crc8_step(crc_r, c);
        cnt_nxt = cnt_inc;
        if (cnt_inc == len_r) state_nxt = (state_r == ST_PAY1) ? ST_CHK1 : ST_CHK2;
      end
      ST_HDR2: begin
        crc_nxt = crc8_step(crc_r, c);
        if (cnt_r == V2_FLAGS) flags_nxt = c;
        else if (cnt_r == V2_FUNC_L) func_nxt = {func_r[15:8], c};
        else if (cnt_r == V2_FUNC_H) func_nxt = {c, func_r[7:0]};
        else if (cnt_r == V2_LEN_L) len_nxt = {len_r[15:8], c};
        else len_nxt = {c, len_r[7:0]};
        cnt_nxt = cnt_inc;
        if (cnt_r >= V2_LAST) begin
          cnt_nxt   = '0;
          state_nxt = (len_nxt == '0) ? ST_CHK2 : ST_PAY2;
        end
      end
      ST_CHK1, ST_CHK2: begin
        ok        = (crc_r == c);
        fail      = (crc_r != c);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      crc_r       <= '0;
      cnt_r       <= '0;
      len_r       <= '0;
      func_r      <= '0;
      flags_r     <= '0;
      kind_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
        crc_r   <= crc_nxt;
        cnt_r   <= cnt_nxt;
        len_r   <= len_nxt;
        func_r  <= func_nxt;
        flags_r <= flags_nxt;
        kind_r  <= kind_nxt;
      end
      if (in_fire) out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pv_r        <= pv;
      pb_r        <= pv ? c : '0;
      pi_r        <= pv ? cnt_r : '0;
      ok_r        <= ok;
      fail_r      <= fail;
      kind_out_r  <= kind_nxt;
      func_out_r  <= func_nxt;
      flags_out_r <= flags_nxt;
      len_out_r   <= len_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.payload_valid = pv_r;
  assign out_bus.payload_byte  = pb_r;
  assign out_bus.payload_index = pi_r;
  assign out_bus.frame_ok      = ok_r;
  assign out_bus.crc_fail      = fail_r;
  assign out_bus.frame_kind    = kind_out_r;
  assign out_bus.function_id   = func_out_r;
  assign out_bus.frame_flags   = flags_out_r;
  assign out_bus.payload_len   = len_out_r;

endmodule

// ===== hw/rtl/msp_chk.sv =====
// Port-level checks for the frame parser, bound into the parser module.
module msp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        payload_valid,
  input logic [15:0] payload_index,
  input logic        frame_ok,
  input logic        crc_fail,
  input logic [2:0]  frame_kind,
  input logic [15:0] payload_len
);
  import msp_pkg::*;

  // A result waiting on the sink holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload_index) && $stable(frame_ok))
    else $error("result beat changed while stalled");

  // Each beat is at most one of payload byte, pass or fail.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({payload_valid, frame_ok, crc_fail}) <= 1)
    else $error("result beat carries more than one status");

  // A payload index always lies inside the declared length.
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && payload_valid |-> payload_index < payload_len)
    else $error("payload index beyond declared length");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> frame_kind <= KIND_V2_RESP)
    else $error("frame kind out of range");

  // Every accepted byte yields a beat on the next cycle.
  a_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result");

endmodule

bind msp_frame_parser msp_chk u_msp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .payload_valid (out_bus.payload_valid),
  .payload_index (out_bus.payload_index),
  .frame_ok      (out_bus.frame_ok),
  .crc_fail      (out_bus.crc_fail),
  .frame_kind    (out_bus.frame_kind),
  .payload_len   (out_bus.payload_len)
);

// ===== dv/msp_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// Testbench for msp_frame_parser: frame-level stimulus with a byte-accurate parser predictor.
module msp_frame_parser_tb;
  import msp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic        pv;
    logic [7:0]  pb;
    logic [15:0] pi;
    logic        ok;
    logic        fail;
    logic [2:0]  kind;
    logic [15:0] func;
    logic [7:0]  flags;
    logic [15:0] len;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  msp_in_if  in_ch ();
  msp_out_if out_ch ();

  msp_frame_parser u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always #6 clk = ~clk;

  // Predictor copy of the parser registers.
  state_t      p_state = ST_IDLE;
  logic [7:0]  p_crc   = '0;
  logic [15:0] p_cnt   = '0;
  logic [15:0] p_len   = '0;
  logic [15:0] p_func  = '0;
  logic [7:0]  p_flags = '0;
  logic [2:0]  p_kind  = KIND_V1_CMD;

  parse_result_t parsed_q[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_ack_cnt = 0;
  int unsigned hold_left   = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned bytes_sent  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned frames_good = 0;
  int unsigned frames_bad  = 0;
  int unsigned payload_beats = 0;

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) r = {r[6:0], 1'b0} ^ CRC_POLY;
      else r = {r[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic string fmt_result(input parse_result_t r);
    return $sformatf("pv=%0d byte=%02h idx=%0d ok=%0d fail=%0d kind=%0d func=%04h flags=%02h len=%0d",
                     r.pv, r.pb, r.pi, r.ok, r.fail, r.kind, r.func, r.flags, r.len);
  endfunction

  task automatic clear_frame_regs();
    p_len   = '0;
    p_func  = '0;
    p_flags = '0;
    p_kind  = KIND_V1_CMD;
    p_cnt   = '0;
    p_crc   = '0;
  endtask

  // Advances the predictor by one received byte and queues the beat it must produce.
  task automatic parse_rx_byte(input logic [7:0] c);
    parse_result_t r;
    r = '0;
    case (p_state)
      ST_IDLE: begin
        if (c == CH_DOLLAR) p_state = ST_START;
      end
      ST_START: begin
        if (c == CH_X) p_state = ST_HDR_X;
        else if (c == CH_M) p_state = ST_HDR_M;
        else p_state = ST_IDLE;
      end
      ST_HDR_M: begin
        clear_frame_regs();
        if (c == CH_QUERY) begin
          p_kind = KIND_V1_FLAG;
          p_state = ST_FLAGS;
        end else if (c == CH_LT) begin
          p_kind = KIND_V1_CMD;
          p_state = ST_SIZE1;
        end else if (c == CH_GT) begin
          p_kind = KIND_V1_RESP;
          p_state = ST_SIZE1;
        end else begin
          p_state = ST_IDLE;
        end
      end
      ST_FLAGS: begin
        p_flags = c;
        p_state = ST_SIZE1;
      end
      ST_SIZE1: begin
        p_len = {8'h00, c};
        p_crc ^= c;
        p_state = ST_FUNC1;
      end
      ST_FUNC1: begin
        p_func = {8'h00, c};
        p_crc ^= c;
        p_cnt = '0;
        if (p_len == 0) p_state = ST_CHK1;
        else p_state = ST_PAY1;
      end
      ST_PAY1, ST_PAY2: begin
        r.pv = 1'b1;
        r.pb = c;
        r.pi = p_cnt;
        if (p_state == ST_PAY1) p_crc ^= c;
        else p_crc = crc8_next(p_crc, c);
        p_cnt = p_cnt + 16'd1;
        if (p_cnt == p_len) begin
          if (p_state == ST_PAY1) p_state = ST_CHK1;
          else p_state = ST_CHK2;
        end
      end
      ST_HDR_X: begin
        clear_frame_regs();
        if (c == CH_LT) begin
          p_kind = KIND_V2_CMD;
          p_state = ST_HDR2;
        end else if (c == CH_GT) begin
          p_kind = KIND_V2_RESP;
          p_state = ST_HDR2;
        end else begin
          p_state = ST_IDLE;
        end
      end
      ST_HDR2: begin
        p_crc = crc8_next(p_crc, c);
        case (p_cnt)
          V2_FLAGS:  p_flags = c;
          V2_FUNC_L: p_func[7:0] = c;
          V2_FUNC_H: p_func[15:8] = c;
          V2_LEN_L:  p_len[7:0] = c;
          default:   p_len[15:8] = c;
        endcase
        p_cnt = p_cnt + 16'd1;
        if (p_cnt > V2_LAST) begin
          p_cnt = '0;
          if (p_len == 0) p_state = ST_CHK2;
          else p_state = ST_PAY2;
        end
      end
      ST_CHK1, ST_CHK2: begin
        if (p_crc == c) r.ok = 1'b1;
        else r.fail = 1'b1;
        p_state = ST_IDLE;
      end
      default: p_state = ST_IDLE;
    endcase
    r.kind  = p_kind;
    r.func  = p_func;
    r.flags = p_flags;
    r.len   = p_len;
    parsed_q.push_back(r);
  endtask

  // Offers one byte, holding it until the parser takes the beat.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_v1_frame(input logic [7:0] type_ch, input logic [7:0] flags,
                               input logic [7:0] len, input logic [7:0] func,
                               input bit corrupt);
    logic [7:0] chk;
    logic [7:0] b;
    chk = len ^ func;
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(type_ch);
    if (type_ch == CH_QUERY) send_byte(flags);
    send_byte(len);
    send_byte(func);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      chk ^= b;
      send_byte(b);
    end
    if (corrupt) chk ^= 8'($urandom_range(255, 1));
    send_byte(chk);
  endtask

  task automatic send_v2_frame(input logic [7:0] type_ch, input logic [7:0] flags,
                               input logic [15:0] func, input logic [15:0] len,
                               input bit corrupt);
    logic [7:0] crc;
    logic [7:0] b;
    logic [7:0] hdr [5];
    hdr = '{flags, func[7:0], func[15:8], len[7:0], len[15:8]};
    crc = '0;
    send_byte(CH_DOLLAR);
    send_byte(CH_X);
    send_byte(type_ch);
    for (int i = 0; i < 5; i++) begin
      crc = crc8_next(crc, hdr[i]);
      send_byte(hdr[i]);
    end
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      crc = crc8_next(crc, b);
      send_byte(b);
    end
    if (corrupt) crc ^= 8'($urandom_range(255, 1));
    send_byte(crc);
  endtask

  // A frame start that the parser must drop: bad second byte or bad type byte.
  task automatic send_broken_header();
    logic [7:0] b;
    int unsigned variant;
    variant = $urandom_range(2);
    send_byte(CH_DOLLAR);
    if (variant == 0) begin
      b = ($urandom_range(3) == 0) ? CH_DOLLAR : 8'($urandom_range(255));
      while (b == CH_M || b == CH_X) b = 8'($urandom_range(255));
      send_byte(b);
    end else if (variant == 1) begin
      send_byte(CH_M);
      b = 8'($urandom_range(255));
      while (b == CH_LT || b == CH_GT || b == CH_QUERY) b = 8'($urandom_range(255));
      send_byte(b);
    end else begin
      send_byte(CH_X);
      b = ($urandom_range(2) == 0) ? CH_QUERY : 8'($urandom_range(255));
      while (b == CH_LT || b == CH_GT) b = 8'($urandom_range(255));
      send_byte(b);
    end
  endtask

  // Line noise between frames; a start marker is kept out so frames stay aligned.
  task automatic send_noise(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == CH_DOLLAR) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic set_idle(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  task automatic test_v1_frames();
    send_v1_frame(CH_LT, 8'h00, 8'h00, 8'h00, 1'b0);
    send_v1_frame(CH_QUERY, 8'hFF, 8'h01, 8'hFF, 1'b1);
  endtask

  task automatic test_v2_frames();
    send_v2_frame(CH_GT, 8'hFF, 16'hFFFF, 16'h0000, 1'b0);
  endtask

  task automatic test_malformed_headers();
    send_byte(CH_DOLLAR);
    send_byte(CH_DOLLAR);
    send_byte(CH_DOLLAR);
    send_byte(CH_X);
    send_byte(CH_QUERY);
  endtask

  // The sink stalls for a long stretch while a maximum-length v1 frame is offered.
  task automatic test_output_hold();
    hold_req_cnt <= hold_req_cnt + 1;
    send_v1_frame(CH_GT, 8'h00, 8'hFF, 8'($urandom_range(255)), 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    logic [7:0] type_ch;
    logic [15:0] len;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        case ($urandom_range(2))
          0: type_ch = CH_LT;
          1: type_ch = CH_GT;
          default: type_ch = CH_QUERY;
        endcase
        len = ($urandom_range(29) == 0) ? 16'($urandom_range(255)) : 16'($urandom_range(6));
        send_v1_frame(type_ch, 8'($urandom_range(255)), len[7:0], 8'($urandom_range(255)),
                      $urandom_range(4) == 0);
      end else if (pick < 75) begin
        type_ch = ($urandom_range(1) == 0) ? CH_LT : CH_GT;
        len = ($urandom_range(29) == 0) ? 16'($urandom_range(300)) : 16'($urandom_range(6));
        send_v2_frame(type_ch, 8'($urandom_range(255)), 16'($urandom_range(65535)), len,
                      $urandom_range(4) == 0);
      end else if (pick < 90) begin
        send_broken_header();
      end else begin
        send_noise($urandom_range(4, 1));
      end
    end
  endtask

  // Result sink: random stalls, or a long counted hold when one is requested.
  always @(posedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left    <= HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{pv: out_ch.payload_valid, pb: out_ch.payload_byte, pi: out_ch.payload_index,
              ok: out_ch.frame_ok, fail: out_ch.crc_fail, kind: out_ch.frame_kind,
              func: out_ch.function_id, flags: out_ch.frame_flags, len: out_ch.payload_len};
      if (parsed_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected beat: %s", fmt_result(got));
      end else begin
        want = parsed_q.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end else begin
          if (want.ok) frames_good++;
          if (want.fail) frames_bad++;
          if (want.pv) payload_beats++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, parsed_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_idle(0, 0);
    test_v1_frames();
    test_v2_frames();
    test_malformed_headers();
    test_output_hold();

    set_idle(32, 83);
    test_random_traffic(400);
    set_idle(83, 32);
    test_random_traffic(400);
    set_idle(0, 0);
    test_random_traffic(400);

    in_ch.valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes: %0d frames passed and %0d failed their checksum, %0d payload beats.",
             bytes_sent, frames_good, frames_bad, payload_beats);
    $display("Traffic ran with source and sink stalls in both ratios, none, and a long sink hold.");
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching beats", mismatch_cnt);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
